// ----- hw/rtl/npq_pkg.sv -----
// Shared types, constants and the fixed palette ROM for the nearest palette color quantizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package npq_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ALPHA_THR = 1'b0;
  localparam logic [8:0] ALPHA_THR_RESET = 9'd128;

  // Distance arithmetic: weights are (1024 + s), 2048 and (1534 - s).
  // The largest total, white against black, is 4606 * 65025 and needs 29 bits.
  localparam int SQ_W = 16;
  localparam int PROD_W = 27;
  localparam int DIST_W = 29;
  localparam logic [10:0] RED_BIAS = 11'd1024;
  localparam logic [10:0] BLUE_BIAS = 11'd1534;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       changed;
  } pix_out_t;

  // Sequencer to distance unit.
  typedef struct packed {
    logic       clear;
    logic       issue;
    logic [7:0] idx;
  } dist_ctrl_t;

  // Distance unit back to the sequencer.
  typedef struct packed {
    logic       busy;
    logic [7:0] idx;
    rgb_t       color;
  } dist_stat_t;

  // Fixed palette: gray ramp, then green, brown, blue, red, yellow, magenta and cyan ramps.
  localparam rgb_t PALETTE_ROM [256] = '{
    {8'd0,8'd0,8'd0},       {8'd8,8'd8,8'd8},       {8'd16,8'd16,8'd16},    {8'd24,8'd24,8'd24},
    {8'd33,8'd33,8'd33},    {8'd41,8'd41,8'd41},    {8'd49,8'd49,8'd49},    {8'd57,8'd57,8'd57},
    {8'd65,8'd65,8'd65},    {8'd73,8'd73,8'd73},    {8'd81,8'd81,8'd81},    {8'd89,8'd89,8'd89},
    {8'd98,8'd98,8'd98},    {8'd106,8'd106,8'd106}, {8'd114,8'd114,8'd114}, {8'd122,8'd122,8'd122},
    {8'd130,8'd130,8'd130}, {8'd138,8'd138,8'd138}, {8'd146,8'd146,8'd146}, {8'd154,8'd154,8'd154},
    {8'd163,8'd163,8'd163}, {8'd171,8'd171,8'd171}, {8'd179,8'd179,8'd179}, {8'd187,8'd187,8'd187},
    {8'd195,8'd195,8'd195}, {8'd203,8'd203,8'd203}, {8'd211,8'd211,8'd211}, {8'd219,8'd219,8'd219},
    {8'd228,8'd228,8'd228}, {8'd236,8'd236,8'd236}, {8'd244,8'd244,8'd244}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd0,8'd17,8'd0},      {8'd0,8'd34,8'd0},      {8'd0,8'd50,8'd0},
    {8'd0,8'd67,8'd0},      {8'd0,8'd84,8'd0},      {8'd0,8'd101,8'd0},     {8'd0,8'd118,8'd0},
    {8'd0,8'd134,8'd0},     {8'd0,8'd151,8'd0},     {8'd0,8'd168,8'd0},     {8'd0,8'd185,8'd0},
    {8'd0,8'd202,8'd0},     {8'd0,8'd218,8'd0},     {8'd0,8'd235,8'd0},     {8'd0,8'd252,8'd0},
    {8'd16,8'd252,8'd16},   {8'd32,8'd252,8'd32},   {8'd47,8'd252,8'd47},   {8'd63,8'd252,8'd63},
    {8'd79,8'd252,8'd79},   {8'd95,8'd252,8'd95},   {8'd110,8'd252,8'd110}, {8'd126,8'd252,8'd126},
    {8'd142,8'd252,8'd142}, {8'd158,8'd252,8'd158}, {8'd173,8'd252,8'd173}, {8'd189,8'd252,8'd189},
    {8'd205,8'd252,8'd205}, {8'd221,8'd252,8'd221}, {8'd236,8'd252,8'd236}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd9,8'd7,8'd3},       {8'd19,8'd13,8'd6},     {8'd28,8'd20,8'd10},
    {8'd37,8'd27,8'd13},    {8'd47,8'd33,8'd16},    {8'd56,8'd40,8'd19},    {8'd65,8'd47,8'd22},
    {8'd75,8'd53,8'd26},    {8'd84,8'd60,8'd29},    {8'd93,8'd67,8'd32},    {8'd103,8'd73,8'd35},
    {8'd112,8'd80,8'd38},   {8'd121,8'd87,8'd42},   {8'd131,8'd93,8'd45},   {8'd140,8'd100,8'd48},
    {8'd147,8'd110,8'd61},  {8'd154,8'd119,8'd74},  {8'd161,8'd129,8'd86},  {8'd168,8'd138,8'd99},
    {8'd175,8'd148,8'd112}, {8'd182,8'd157,8'd125}, {8'd189,8'd167,8'd137}, {8'd196,8'd176,8'd150},
    {8'd203,8'd186,8'd163}, {8'd210,8'd195,8'd176}, {8'd217,8'd205,8'd188}, {8'd224,8'd214,8'd201},
    {8'd231,8'd224,8'd214}, {8'd238,8'd233,8'd227}, {8'd245,8'd243,8'd239}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd0,8'd0,8'd17},      {8'd0,8'd0,8'd34},      {8'd0,8'd0,8'd51},
    {8'd0,8'd0,8'd68},      {8'd0,8'd0,8'd85},      {8'd0,8'd0,8'd102},     {8'd0,8'd0,8'd119},
    {8'd0,8'd0,8'd136},     {8'd0,8'd0,8'd153},     {8'd0,8'd0,8'd170},     {8'd0,8'd0,8'd187},
    {8'd0,8'd0,8'd204},     {8'd0,8'd0,8'd221},     {8'd0,8'd0,8'd238},     {8'd0,8'd0,8'd255},
    {8'd16,8'd16,8'd255},   {8'd32,8'd32,8'd255},   {8'd47,8'd47,8'd254},   {8'd63,8'd63,8'd254},
    {8'd79,8'd79,8'd254},   {8'd95,8'd95,8'd254},   {8'd110,8'd110,8'd254}, {8'd126,8'd126,8'd254},
    {8'd142,8'd142,8'd253}, {8'd158,8'd158,8'd253}, {8'd173,8'd173,8'd253}, {8'd189,8'd189,8'd253},
    {8'd205,8'd205,8'd253}, {8'd221,8'd221,8'd252}, {8'd236,8'd236,8'd252}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd17,8'd0,8'd0},      {8'd34,8'd0,8'd0},      {8'd50,8'd0,8'd0},
    {8'd67,8'd0,8'd0},      {8'd84,8'd0,8'd0},      {8'd101,8'd0,8'd0},     {8'd118,8'd0,8'd0},
    {8'd134,8'd0,8'd0},     {8'd151,8'd0,8'd0},     {8'd168,8'd0,8'd0},     {8'd185,8'd0,8'd0},
    {8'd202,8'd0,8'd0},     {8'd218,8'd0,8'd0},     {8'd235,8'd0,8'd0},     {8'd252,8'd0,8'd0},
    {8'd252,8'd16,8'd16},   {8'd252,8'd32,8'd32},   {8'd252,8'd47,8'd47},   {8'd252,8'd63,8'd63},
    {8'd252,8'd79,8'd79},   {8'd252,8'd95,8'd95},   {8'd252,8'd110,8'd110}, {8'd252,8'd126,8'd126},
    {8'd252,8'd142,8'd142}, {8'd252,8'd158,8'd158}, {8'd252,8'd173,8'd173}, {8'd252,8'd189,8'd189},
    {8'd252,8'd205,8'd205}, {8'd252,8'd221,8'd221}, {8'd252,8'd236,8'd236}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd17,8'd17,8'd0},     {8'd34,8'd34,8'd0},     {8'd51,8'd51,8'd0},
    {8'd68,8'd68,8'd0},     {8'd85,8'd85,8'd0},     {8'd102,8'd102,8'd0},   {8'd119,8'd119,8'd0},
    {8'd136,8'd136,8'd0},   {8'd153,8'd153,8'd0},   {8'd170,8'd170,8'd0},   {8'd187,8'd187,8'd0},
    {8'd204,8'd204,8'd0},   {8'd221,8'd221,8'd0},   {8'd238,8'd238,8'd0},   {8'd255,8'd255,8'd0},
    {8'd255,8'd255,8'd16},  {8'd255,8'd255,8'd32},  {8'd254,8'd254,8'd47},  {8'd254,8'd254,8'd63},
    {8'd254,8'd254,8'd79},  {8'd254,8'd254,8'd95},  {8'd254,8'd254,8'd110}, {8'd254,8'd254,8'd126},
    {8'd253,8'd253,8'd142}, {8'd253,8'd253,8'd158}, {8'd253,8'd253,8'd173}, {8'd253,8'd253,8'd189},
    {8'd253,8'd253,8'd205}, {8'd252,8'd252,8'd221}, {8'd252,8'd252,8'd236}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd17,8'd0,8'd17},     {8'd34,8'd0,8'd34},     {8'd51,8'd0,8'd51},
    {8'd68,8'd0,8'd68},     {8'd85,8'd0,8'd85},     {8'd102,8'd0,8'd102},   {8'd119,8'd0,8'd119},
    {8'd136,8'd0,8'd136},   {8'd153,8'd0,8'd153},   {8'd170,8'd0,8'd170},   {8'd187,8'd0,8'd187},
    {8'd204,8'd0,8'd204},   {8'd221,8'd0,8'd221},   {8'd238,8'd0,8'd238},   {8'd255,8'd0,8'd255},
    {8'd255,8'd16,8'd255},  {8'd255,8'd32,8'd255},  {8'd254,8'd47,8'd254},  {8'd254,8'd63,8'd254},
    {8'd254,8'd79,8'd254},  {8'd254,8'd95,8'd254},  {8'd254,8'd110,8'd254}, {8'd254,8'd126,8'd254},
    {8'd253,8'd142,8'd253}, {8'd253,8'd158,8'd253}, {8'd253,8'd173,8'd253}, {8'd253,8'd189,8'd253},
    {8'd253,8'd205,8'd253}, {8'd252,8'd221,8'd252}, {8'd252,8'd236,8'd252}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd0},       {8'd0,8'd17,8'd17},     {8'd0,8'd34,8'd34},     {8'd0,8'd51,8'd51},
    {8'd0,8'd68,8'd68},     {8'd0,8'd85,8'd85},     {8'd0,8'd102,8'd102},   {8'd0,8'd119,8'd119},
    {8'd0,8'd136,8'd136},   {8'd0,8'd153,8'd153},   {8'd0,8'd170,8'd170},   {8'd0,8'd187,8'd187},
    {8'd0,8'd204,8'd204},   {8'd0,8'd221,8'd221},   {8'd0,8'd238,8'd238},   {8'd0,8'd255,8'd255},
    {8'd16,8'd255,8'd255},  {8'd32,8'd255,8'd255},  {8'd47,8'd254,8'd254},  {8'd63,8'd254,8'd254},
    {8'd79,8'd254,8'd254},  {8'd95,8'd254,8'd254},  {8'd110,8'd254,8'd254}, {8'd126,8'd254,8'd254},
    {8'd142,8'd253,8'd253}, {8'd158,8'd253,8'd253}, {8'd173,8'd253,8'd253}, {8'd189,8'd253,8'd253},
    {8'd205,8'd253,8'd253}, {8'd221,8'd252,8'd252}, {8'd236,8'd252,8'd252}, {8'd252,8'd252,8'd252}
  };

endpackage

// ----- hw/rtl/npq_cfg.sv -----
// Configuration register file of the quantizer: the alpha threshold behind an APB-style port.
// Depends on npq_pkg for the address width, register index and reset value.
module npq_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [npq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [npq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [npq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic [8:0]                     alpha_thr
);

  logic [8:0] alpha_thr_r;
  logic       sel_thr;

  // Word index is the address above the byte offset.
  assign sel_thr = (cfg_paddr[2] == npq_pkg::REG_ALPHA_THR);

  // The threshold is written on the access phase of a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_thr_r <= npq_pkg::ALPHA_THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_thr) begin
      alpha_thr_r <= cfg_pwdata[8:0];
    end
  end

  // Reads return the register, or zero beyond it.
  assign cfg_prdata = sel_thr ? {{(npq_pkg::CFG_DATA_W-9){1'b0}}, alpha_thr_r}
                              : '0;
  assign cfg_pready = 1'b1;
  assign alpha_thr  = alpha_thr_r;

endmodule

// ----- hw/rtl/npq_dist.sv -----
// Shared redmean distance unit: squares, weighted products, then sum and running minimum.
// Depends on npq_pkg for the palette ROM, widths and the control and status structs.
module npq_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  npq_pkg::rgb_t       pix,
  input  npq_pkg::dist_ctrl_t ctrl,
  output npq_pkg::dist_stat_t stat
);

  npq_pkg::rgb_t pal;
  logic [7:0] dr;
  logic [7:0] dg;
  logic [7:0] db;

  logic                       s1_vld_r;
  logic [7:0]                 s1_idx_r;
  npq_pkg::rgb_t              s1_col_r;
  logic [npq_pkg::SQ_W-1:0]   s1_sqr_r;
  logic [npq_pkg::SQ_W-1:0]   s1_sqg_r;
  logic [npq_pkg::SQ_W-1:0]   s1_sqb_r;
  logic [8:0]                 s1_sum_r;

  logic [10:0]                wr;
  logic [10:0]                wb;
  logic                       s2_vld_r;
  logic [7:0]                 s2_idx_r;
  npq_pkg::rgb_t              s2_col_r;
  logic [npq_pkg::PROD_W-1:0] s2_pr_r;
  logic [npq_pkg::PROD_W-1:0] s2_pg_r;
  logic [npq_pkg::PROD_W-1:0] s2_pb_r;

  logic [npq_pkg::DIST_W-1:0] cur_d;
  logic                       found_r;
  logic [npq_pkg::DIST_W-1:0] best_d_r;
  logic [7:0]                 best_idx_r;
  npq_pkg::rgb_t              best_col_r;

  // Stage one: ROM read, absolute channel differences, their squares and the red sum.
  always_comb begin
    pal = npq_pkg::PALETTE_ROM[ctrl.idx];
    dr  = (pix.r > pal.r) ? (pix.r - pal.r) : (pal.r - pix.r);
    dg  = (pix.g > pal.g) ? (pix.g - pal.g) : (pal.g - pix.g);
    db  = (pix.b > pal.b) ? (pix.b - pal.b) : (pal.b - pix.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      s1_idx_r <= ctrl.idx;
      s1_col_r <= pal;
      s1_sqr_r <= npq_pkg::SQ_W'(dr) * npq_pkg::SQ_W'(dr);
      s1_sqg_r <= npq_pkg::SQ_W'(dg) * npq_pkg::SQ_W'(dg);
      s1_sqb_r <= npq_pkg::SQ_W'(db) * npq_pkg::SQ_W'(db);
      s1_sum_r <= 9'(pix.r) + 9'(pal.r);
    end
  end

  // Stage two: weight the squares; green weight is a plain shift.
  assign wr = npq_pkg::RED_BIAS + 11'(s1_sum_r);
  assign wb = npq_pkg::BLUE_BIAS - 11'(s1_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_idx_r <= s1_idx_r;
      s2_col_r <= s1_col_r;
      s2_pr_r  <= npq_pkg::PROD_W'(wr) * npq_pkg::PROD_W'(s1_sqr_r);
      s2_pg_r  <= {s1_sqg_r, 11'd0};
      s2_pb_r  <= npq_pkg::PROD_W'(wb) * npq_pkg::PROD_W'(s1_sqb_r);
    end
  end

  // Stage three: total distance against the best so far; a strict less keeps the lower index.
  assign cur_d = npq_pkg::DIST_W'(s2_pr_r) + npq_pkg::DIST_W'(s2_pg_r)
               + npq_pkg::DIST_W'(s2_pb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (s2_vld_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && (!found_r || (cur_d < best_d_r))) begin
      best_d_r   <= cur_d;
      best_idx_r <= s2_idx_r;
      best_col_r <= s2_col_r;
    end
  end

  assign stat.busy  = s1_vld_r | s2_vld_r;
  assign stat.idx   = best_idx_r;
  assign stat.color = best_col_r;

endmodule

// ----- hw/rtl/nearest_palette_color_quantizer.sv -----
// An opaque pixel is searched against the palette and then emitted; a transparent one goes straight
// to the output register. A new pixel is taken only after the last one has been loaded for output.
// The search runs on the single distance unit, which sees one palette entry per cycle, plus its
// three-stage pipeline drain. The result waits in an output register while the next pixel runs.
// Reset (synchronous, active low) idles the sequencer, empties the output and sets the threshold to
// 128; the palette ROM is constant. Depends on npq_pkg, npq_cfg and npq_dist.
module nearest_palette_color_quantizer #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  npq_pkg::pix_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output npq_pkg::pix_out_t              out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [npq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [npq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [npq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam logic [7:0] LAST_IDX = 8'(PALETTE_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  npq_pkg::pix_in_t    pix_r;
  logic                trans_r;
  logic [7:0]          addr_r;
  logic [7:0]          addr_nxt;
  logic                out_valid_r;
  npq_pkg::pix_out_t   out_r;
  npq_pkg::pix_out_t   res;
  logic [8:0]          alpha_thr;
  logic                in_take;
  logic                is_trans;
  logic                out_load;
  npq_pkg::dist_ctrl_t ctrl;
  npq_pkg::dist_stat_t stat;
  npq_pkg::rgb_t       pix_rgb;

  npq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .alpha_thr   (alpha_thr)
  );

  assign pix_rgb = '{r: pix_r.red, g: pix_r.green, b: pix_r.blue};

  npq_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .pix   (pix_rgb),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // Input handshake: a pixel is taken only while the sequencer idles.
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign is_trans = ({1'b0, in_data.alpha} < alpha_thr);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Distance unit control: clear the minimum on acceptance, feed one entry per search cycle.
  assign ctrl.clear = in_take;
  assign ctrl.issue = (state_r == ST_SEARCH);
  assign ctrl.idx   = addr_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    case (state_r)
      ST_IDLE: begin
        addr_nxt = 8'd1;
        if (in_take) begin
          state_nxt = is_trans ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        addr_nxt = addr_r + 8'd1;
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= 8'd1;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // The pixel is held for the whole search.
  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r   <= in_data;
      trans_r <= is_trans;
    end
  end

  // Result word: transparent zero or the winning entry, and the changed flag against the input.
  always_comb begin
    res.color_index = trans_r ? 8'd0 : stat.idx;
    res.out_red     = trans_r ? 8'd0 : stat.color.r;
    res.out_green   = trans_r ? 8'd0 : stat.color.g;
    res.out_blue    = trans_r ? 8'd0 : stat.color.b;
    res.out_alpha   = trans_r ? 8'd0 : npq_pkg::ALPHA_OPAQUE;
    res.changed     = (res.out_red != pix_r.red) || (res.out_green != pix_r.green)
                   || (res.out_blue != pix_r.blue) || (res.out_alpha != pix_r.alpha);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
